### rtl/core/tiled_outer_product_mac_defines.svh
// Assertion macros shared by the tile multiply-accumulate RTL.
// Each macro expects clk and rst in scope; checks are off during reset.
`ifndef TILED_OUTER_PRODUCT_MAC_DEFINES_SVH
`define TILED_OUTER_PRODUCT_MAC_DEFINES_SVH

// Same-cycle implication.
`define TOMAC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tomac: same-cycle check failed");

// Next-cycle implication.
`define TOMAC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tomac: next-cycle check failed");

`endif

### rtl/core/tomac_pkg.sv
`default_nettype none

package tomac_pkg;

  localparam int TILE_ROWS  = 4;
  localparam int TILE_COLS  = 4;
  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 48;

  localparam int NUM_ACC = TILE_ROWS * TILE_COLS;
  localparam int PROD_W  = 2 * DATA_WIDTH;
  localparam int WIDE_W  = (PROD_W > ACC_WIDTH) ? PROD_W : ACC_WIDTH;
  localparam int SUM_W   = ACC_WIDTH + 1;
  localparam int ROW_W   = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
  localparam int COL_W   = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic [ROW_W-1:0]             row_t;
  typedef logic [COL_W-1:0]             col_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Control from the pipeline to the MAC array.
  typedef struct packed {
    logic load_prod;   // capture products of the input stage
    logic accumulate;  // fold the product stage into the accumulators
    logic dump;        // that fold closes the tile: clear afterwards
  } mac_step_t;

  // Clamp the product to the accumulator range, then add with saturation.
  function automatic acc_t sat_add(acc_t acc, prod_t p);
    logic signed [WIDE_W-1:0] pw;
    acc_t                     pc;
    logic signed [SUM_W-1:0]  s;
    acc_t                     res;
    pw = WIDE_W'(p);
    if (pw > WIDE_W'(ACC_MAX)) begin
      pc = ACC_MAX;
    end else if (pw < WIDE_W'(ACC_MIN)) begin
      pc = ACC_MIN;
    end else begin
      pc = pw[ACC_WIDTH-1:0];
    end
    s = SUM_W'(acc) + SUM_W'(pc);
    if (s[SUM_W-1] != s[SUM_W-2]) begin
      res = s[SUM_W-1] ? ACC_MIN : ACC_MAX;
    end else begin
      res = s[ACC_WIDTH-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tomac_mac_array.sv
`default_nettype none

module tomac_mac_array (
  input  wire                  clk,
  input  wire                  rst,
  input  tomac_pkg::mac_step_t step,
  input  tomac_pkg::data_t     a   [tomac_pkg::TILE_ROWS],
  input  tomac_pkg::data_t     b   [tomac_pkg::TILE_COLS],
  output tomac_pkg::acc_t      sums[tomac_pkg::NUM_ACC]
);

  tomac_pkg::prod_t prod[tomac_pkg::NUM_ACC];
  tomac_pkg::acc_t  acc [tomac_pkg::NUM_ACC];

  for (genvar r = 0; r < tomac_pkg::TILE_ROWS; r++) begin : g_row
    for (genvar c = 0; c < tomac_pkg::TILE_COLS; c++) begin : g_col
      localparam int Idx = r * tomac_pkg::TILE_COLS + c;

      // updated sum of this cell, also the value handed out at tile end
      assign sums[Idx] = tomac_pkg::sat_add(acc[Idx], prod[Idx]);

      always_ff @(posedge clk) begin
        if (step.load_prod) begin
          prod[Idx] <= a[r] * b[c];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          acc[Idx] <= '0;
        end else if (step.accumulate) begin
          acc[Idx] <= step.dump ? '0 : sums[Idx];
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/tomac_drain.sv
`default_nettype none
`include "tiled_outer_product_mac_defines.svh"

module tomac_drain (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     load,
  input  tomac_pkg::acc_t         sums[tomac_pkg::NUM_ACC],
  output logic                    ready,
  output logic                    out_valid,
  input  wire                     out_stall,
  output tomac_pkg::row_t         tile_row,
  output tomac_pkg::col_t         tile_col,
  output tomac_pkg::acc_t         sum_value,
  output logic                    last_of_tile
);

  tomac_pkg::acc_t bank[tomac_pkg::NUM_ACC];
  tomac_pkg::row_t row;
  tomac_pkg::col_t col;
  logic            busy;
  logic            final_beat;
  logic            out_xfer;

  assign final_beat = busy
                      && (row == tomac_pkg::ROW_W'(tomac_pkg::TILE_ROWS - 1))
                      && (col == tomac_pkg::COL_W'(tomac_pkg::TILE_COLS - 1));
  assign out_xfer   = busy && !out_stall;
  assign ready      = !busy || (final_beat && !out_stall);

  assign out_valid    = busy;
  assign tile_row     = row;
  assign tile_col     = col;
  assign sum_value    = bank[0];
  assign last_of_tile = final_beat;

  // shift toward the head on each transfer
  always_ff @(posedge clk) begin
    if (load) begin
      bank <= sums;
    end else if (out_xfer) begin
      for (int i = 0; i < tomac_pkg::NUM_ACC - 1; i++) begin
        bank[i] <= bank[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
      col  <= '0;
    end else begin
      priority if (load) begin
        busy <= 1'b1;
        row  <= '0;
        col  <= '0;
      end else if (out_xfer) begin
        if (final_beat) begin
          busy <= 1'b0;
        end
        if (col == tomac_pkg::COL_W'(tomac_pkg::TILE_COLS - 1)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  `TOMAC_ASSERT_IMP(a_load_only_when_free, load, !busy || (final_beat && !out_stall))
  `TOMAC_ASSERT_NXT(a_load_starts_at_origin, load, busy && row == '0 && col == '0)
  `TOMAC_ASSERT_NXT(a_final_ends_tile, final_beat && !out_stall && !load, !busy)
  `TOMAC_ASSERT_NXT(a_mid_tile_stays_busy, busy && !final_beat && !load, busy)

endmodule

`default_nettype wire

### rtl/core/tiled_outer_product_mac.sv
// Channel | Dir | Handshake            | Payload
// --------+-----+----------------------+--------------------------------------------
// in      | in  | in_valid / in_stall  | a_row0..3, b_col0..3 (s16 Q1.15), last_k
// out     | out | out_valid / out_stall| tile_row, tile_col, sum_value (s48), last_of_tile
//
// One k step is taken every cycle while in_stall is low: input register, product
// register, then the saturating add into the 16 accumulators; an item passes
// both registers before it reaches the accumulators. A tile's sums appear on
// the output from the cycle after its last step folds in, one per cycle while
// out_stall is low, row-major. in_stall rises only when a finished tile waits
// in the product stage while the previous tile is still draining (a tile of
// fewer than 16 steps, or out_stall holding the drain back); reset is
// synchronous and clears the accumulators, the valids and the drain state.
`default_nettype none
`include "tiled_outer_product_mac_defines.svh"

module tiled_outer_product_mac (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  tomac_pkg::data_t        a_row0,
  input  tomac_pkg::data_t        a_row1,
  input  tomac_pkg::data_t        a_row2,
  input  tomac_pkg::data_t        a_row3,
  input  tomac_pkg::data_t        b_col0,
  input  tomac_pkg::data_t        b_col1,
  input  tomac_pkg::data_t        b_col2,
  input  tomac_pkg::data_t        b_col3,
  input  wire                     last_k,
  output logic                    out_valid,
  input  wire                     out_stall,
  output tomac_pkg::row_t         tile_row,
  output tomac_pkg::col_t         tile_col,
  output tomac_pkg::acc_t         sum_value,
  output logic                    last_of_tile
);

  tomac_pkg::data_t    a_in[tomac_pkg::TILE_ROWS];
  tomac_pkg::data_t    b_in[tomac_pkg::TILE_COLS];

  // Input stage
  tomac_pkg::data_t    a1[tomac_pkg::TILE_ROWS];
  tomac_pkg::data_t    b1[tomac_pkg::TILE_COLS];
  logic                v1;
  logic                last1;

  // Product stage control (products live in the MAC array)
  logic                v2;
  logic                last2;

  logic                s2_free;
  logic                drain_ready;
  logic                drain_load;
  tomac_pkg::mac_step_t step;
  tomac_pkg::acc_t     sums[tomac_pkg::NUM_ACC];

  assign a_in[0] = a_row0;
  assign a_in[1] = a_row1;
  assign a_in[2] = a_row2;
  assign a_in[3] = a_row3;
  assign b_in[0] = b_col0;
  assign b_in[1] = b_col1;
  assign b_in[2] = b_col2;
  assign b_in[3] = b_col3;

  // The product stage can move on unless it holds a tile end the drain can't take.
  assign s2_free    = !v2 || !last2 || drain_ready;
  assign in_stall   = v1 && !s2_free;
  assign drain_load = v2 && last2 && s2_free;

  assign step.load_prod  = v1 && s2_free;
  assign step.accumulate = v2 && s2_free;
  assign step.dump       = last2;

  // Capture a transfer; hold while stalled.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a1    <= a_in;
      b1    <= b_in;
      last1 <= last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      last2 <= 1'b0;
    end else begin
      if (!in_stall) begin
        v1 <= in_valid;
      end
      if (s2_free) begin
        v2    <= v1;
        last2 <= last1;
      end
    end
  end

  tomac_mac_array u_mac_array (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .a    (a1),
    .b    (b1),
    .sums (sums)
  );

  tomac_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .load         (drain_load),
    .sums         (sums),
    .ready        (drain_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tile_row     (tile_row),
    .tile_col     (tile_col),
    .sum_value    (sum_value),
    .last_of_tile (last_of_tile)
  );

  `TOMAC_ASSERT_IMP(a_stall_only_on_tile_end, in_stall, v2 && last2 && out_valid)
  `TOMAC_ASSERT_NXT(a_blocked_end_holds, v2 && last2 && !s2_free, v2 && last2)
  `TOMAC_ASSERT_NXT(a_dump_starts_drain, drain_load, out_valid)

endmodule

`default_nettype wire
